// ===== src/dgl_pkg.sv =====
// ----------------------------------------------------------------------------
// dgl_pkg - dome gate leaf controller package
// Command, mode and direction codes, state types and the per-gate event logic.
// ----------------------------------------------------------------------------
package dgl_pkg;

  localparam int MAX_GATES    = 2;
  localparam int FULL_ANGLE   = 90;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int S_TDATA_W    = 40;
  localparam int S_TUSER_W    = 3;
  localparam int M_TDATA_W    = 56;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PWM_BRAKE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PWM_RUN     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_BRAKE = 2'd2;

  // event commands
  localparam logic [2:0] CMD_TICK     = 3'd0;
  localparam logic [2:0] CMD_CLOSE    = 3'd1;
  localparam logic [2:0] CMD_OPEN     = 3'd2;
  localparam logic [2:0] CMD_LIMIT    = 3'd3;
  localparam logic [2:0] CMD_RAIN     = 3'd4;
  localparam logic [2:0] CMD_GOTO     = 3'd5;
  localparam logic [2:0] CMD_STOP_ALL = 3'd6;

  localparam logic [1:0] MODE_STOP    = 2'd0;
  localparam logic [1:0] MODE_CLOSING = 2'd1;
  localparam logic [1:0] MODE_OPENING = 2'd2;

  localparam logic [1:0] DIR_STOP  = 2'd0;
  localparam logic [1:0] DIR_CLOSE = 2'd1;
  localparam logic [1:0] DIR_OPEN  = 2'd2;

  localparam logic [7:0] DEG_UNKNOWN = 8'hFF;

  typedef struct packed {
    logic [15:0] pwm_brake;
    logic [15:0] pwm_run;
    logic [5:0]  angle_brake;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [6:0]  tgt;
    logic        tgt_valid;
    logic [15:0] speed;
    logic [1:0]  dir0;
    logic [1:0]  dir1;
    logic        end_lamp;
  } gate_st_t;

  // what one gate sees of the event
  typedef struct packed {
    logic [3:0] sensors;
    logic [6:0] angle;
    logic       angle_ok;
  } gate_ev_t;

  typedef struct packed {
    gate_st_t   st;
    logic       mode_set;
    logic       mode_on;
    logic [1:0] save;
    logic [1:0] save_closed;
  } gate_res_t;

  function automatic logic [15:0] drive_level(cfg_t c, logic [1:0] mode, gate_ev_t e);
    logic [7:0]  sum;
    logic [15:0] lvl;
    sum = {1'b0, e.angle} + {2'b00, c.angle_brake};
    lvl = 16'd0;
    if (!e.angle_ok) begin
      lvl = c.pwm_brake;
    end else if (mode == MODE_CLOSING) begin
      lvl = (sum < 8'(FULL_ANGLE)) ? c.pwm_run : c.pwm_brake;
    end else if (mode == MODE_OPENING) begin
      lvl = (e.angle > {1'b0, c.angle_brake}) ? c.pwm_run : c.pwm_brake;
    end
    return lvl;
  endfunction

  function automatic gate_res_t set_mode(gate_res_t r, logic [1:0] m);
    gate_res_t q;
    q = r;
    q.st.mode   = m;
    q.mode_set  = 1'b1;
    q.mode_on   = (m != MODE_STOP);
    if (m != MODE_STOP) begin
      q.st.end_lamp = 1'b0;
    end
    return q;
  endfunction

  function automatic gate_res_t halt_gate(gate_res_t r);
    gate_res_t q;
    q = set_mode(r, MODE_STOP);
    q.st.dir0  = DIR_STOP;
    q.st.dir1  = DIR_STOP;
    q.st.speed = 16'd0;
    return q;
  endfunction

  function automatic gate_res_t run_gate(gate_res_t r, logic closing, gate_ev_t e, cfg_t c);
    gate_res_t  q;
    logic       at1;
    logic       at2;
    logic [1:0] d;
    q   = r;
    at1 = closing ? e.sensors[0] : e.sensors[1];
    at2 = closing ? e.sensors[2] : e.sensors[3];
    d   = closing ? DIR_CLOSE : DIR_OPEN;
    if (!at1 || !at2) begin
      q = set_mode(q, closing ? MODE_CLOSING : MODE_OPENING);
      q.st.speed = drive_level(c, q.st.mode, e);
    end
    if (!at1) begin
      q.st.dir0 = d;
    end
    if (!at2) begin
      q.st.dir1 = d;
    end
    return q;
  endfunction

  function automatic gate_res_t goto_angle(gate_res_t r, logic [6:0] a, gate_ev_t e, cfg_t c);
    gate_res_t  q;
    logic [6:0] a_sat;
    logic [6:0] need;
    logic [7:0] deg;
    q     = r;
    a_sat = (a > 7'(FULL_ANGLE)) ? 7'(FULL_ANGLE) : a;
    need  = 7'(FULL_ANGLE) - a_sat;
    deg   = e.angle_ok ? {1'b0, e.angle} : DEG_UNKNOWN;
    q.st.tgt_valid = 1'b0;
    if (need == 7'd0) begin
      q = run_gate(q, 1'b0, e, c);
    end else if (need == 7'(FULL_ANGLE)) begin
      q = run_gate(q, 1'b1, e, c);
    end else if (deg != {1'b0, need}) begin
      q.st.tgt       = need;
      q.st.tgt_valid = 1'b1;
      q = run_gate(q, deg <= {1'b0, need}, e, c);
    end
    return q;
  endfunction

  // next state of one gate for one event
  function automatic gate_res_t gate_step(gate_st_t st, logic [2:0] cmd, logic sel,
                                          logic [1:0] si, gate_ev_t e, logic [6:0] open_a,
                                          logic wet, cfg_t c);
    gate_res_t   r;
    logic [7:0]  deg;
    logic [15:0] sp;
    logic        dir_match;
    r             = '0;
    r.st          = st;
    deg           = e.angle_ok ? {1'b0, e.angle} : DEG_UNKNOWN;
    dir_match     = ((st.mode == MODE_CLOSING) && !si[0]) ||
                    ((st.mode == MODE_OPENING) && si[0]);
    unique case (cmd)
      CMD_TICK: begin
        if (r.st.tgt_valid) begin
          if (r.st.mode == MODE_CLOSING && deg >= {1'b0, r.st.tgt}) begin
            r = halt_gate(r);
          end
          if (r.st.mode == MODE_OPENING && deg <= {1'b0, r.st.tgt}) begin
            r = halt_gate(r);
          end
        end
        sp = drive_level(c, r.st.mode, e);
        if (sp != r.st.speed) begin
          r.st.speed = sp;
          if (r.st.mode == MODE_CLOSING) begin
            r = run_gate(r, 1'b1, e, c);
          end else if (r.st.mode == MODE_OPENING) begin
            r = run_gate(r, 1'b0, e, c);
          end
        end
      end
      CMD_CLOSE, CMD_OPEN: begin
        if (sel) begin
          if (r.st.mode == MODE_STOP) begin
            r = run_gate(r, cmd == CMD_CLOSE, e, c);
          end else begin
            r = halt_gate(r);
          end
          r.st.tgt_valid = 1'b0;
        end
      end
      CMD_LIMIT: begin
        if (sel && dir_match) begin
          // stop one leaf, report its end, stop the gate when both are still
          r.save[si[1]] = 1'b1;
          r.save_closed[si[1]] = (st.mode == MODE_CLOSING);
          if (!si[1]) begin
            r.st.dir0 = DIR_STOP;
            if (r.st.dir1 == DIR_STOP) begin
              r.st.end_lamp = 1'b1;
              r = set_mode(r, MODE_STOP);
            end
          end else begin
            r.st.dir1 = DIR_STOP;
            if (r.st.dir0 == DIR_STOP) begin
              r.st.end_lamp = 1'b1;
              r = set_mode(r, MODE_STOP);
            end
          end
        end
      end
      CMD_RAIN: begin
        if (wet) begin
          r = goto_angle(r, 7'd0, e, c);
        end
      end
      CMD_GOTO: begin
        if (sel) begin
          r = goto_angle(r, open_a, e, c);
        end
      end
      CMD_STOP_ALL: begin
        r = halt_gate(r);
      end
      default: begin
      end
    endcase
    return r;
  endfunction

endpackage

// ===== src/dome_gate_leaf_controller_top.sv =====
// ----------------------------------------------------------------------------
// dome_gate_leaf_controller_top - dome gate leaf controller
// Mode, leaf and drive-level control for up to two dome gates.
// ----------------------------------------------------------------------------
// Events enter on the s_ stream: s_tuser carries the command, s_tdata the
// gate, limit sensor, angle and rain fields. Each accepted word produces
// exactly one result word on the m_ stream with the motor directions, drive
// levels, gate modes, lamps and the end positions to save.
// Gate state and the result register load on the same edge that accepts the
// event. One event is taken every cycle; the result register is the only
// stage, so s_tready stays high while that register is empty or being
// emptied in the same cycle.
// When the receiver stalls with a result held, s_tready drops until that
// word is taken; nothing is lost or repeated.
// The cfg port writes pwm_brake, the mid-travel drive level or angle_brake,
// one per write, and is meant to be used while no event is in flight.
// Synchronous reset stops both gates, clears targets, speeds and lamps,
// empties the result register and loads the register defaults.
// ----------------------------------------------------------------------------
module dome_gate_leaf_controller_top #(
  parameter int NUM_GATES = 2
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // gate, sensor_index, sensors_now, angle_gate0, angle_gate1, angle_valid,
  // open_angle, rain_wet, zero fill
  input  logic [dgl_pkg::S_TDATA_W-1:0]  s_tdata,
  // command
  input  logic [dgl_pkg::S_TUSER_W-1:0]  s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // motor_dirs, speed_gate0, speed_gate1, gate_modes, lamps, save_mask,
  // save_at_closed
  output logic [dgl_pkg::M_TDATA_W-1:0]  m_tdata,
  input  logic                           cfg_we,
  input  logic [dgl_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [dgl_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dgl_pkg::*;

  cfg_t      cfg;
  gate_st_t  gate_st      [NUM_GATES];
  gate_res_t gate_res     [NUM_GATES];
  logic      move_lamp;
  logic      move_lamp_next;
  logic      rain_lamp;
  logic      rain_lamp_next;
  logic      accept;

  logic [2:0] in_cmd;
  logic       in_gate;
  logic [1:0] in_si;
  logic [7:0] in_sensors;
  logic [6:0] in_angle [MAX_GATES];
  logic [1:0] in_valid;
  logic [6:0] in_open;
  logic       in_wet;

  logic [7:0]  res_dirs;
  logic [15:0] res_speed [MAX_GATES];
  logic [3:0]  res_modes;
  logic [1:0]  res_end;
  logic [3:0]  res_save;
  logic [3:0]  res_save_closed;

  assign in_cmd      = s_tuser;
  assign in_gate     = s_tdata[0];
  assign in_si       = s_tdata[2:1];
  assign in_sensors  = s_tdata[10:3];
  assign in_angle[0] = s_tdata[17:11];
  assign in_angle[1] = s_tdata[24:18];
  assign in_valid    = s_tdata[26:25];
  assign in_open     = s_tdata[33:27];
  assign in_wet      = s_tdata[34];

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    gate_ev_t ev;
    for (int g = 0; g < NUM_GATES; g++) begin
      ev.sensors  = in_sensors[4*g +: 4];
      ev.angle    = in_angle[g];
      ev.angle_ok = in_valid[g];
      gate_res[g] = gate_step(gate_st[g], in_cmd, in_gate == 1'(g), in_si, ev,
                              in_open, in_wet, cfg);
    end
  end

  // the highest-numbered gate that changes mode decides the move lamp
  always_comb begin
    move_lamp_next = move_lamp;
    for (int g = 0; g < NUM_GATES; g++) begin
      if (gate_res[g].mode_set) begin
        move_lamp_next = gate_res[g].mode_on;
      end
    end
    rain_lamp_next = rain_lamp;
    if (in_cmd == CMD_RAIN) begin
      rain_lamp_next = in_wet;
    end
  end

  always_comb begin
    res_dirs        = '0;
    res_modes       = '0;
    res_end         = '0;
    res_save        = '0;
    res_save_closed = '0;
    for (int g = 0; g < MAX_GATES; g++) begin
      res_speed[g] = '0;
    end
    for (int g = 0; g < NUM_GATES; g++) begin
      res_dirs[4*g +: 4]        = {gate_res[g].st.dir1, gate_res[g].st.dir0};
      res_speed[g]              = gate_res[g].st.speed;
      res_modes[2*g +: 2]       = gate_res[g].st.mode;
      res_end[g]                = gate_res[g].st.end_lamp;
      res_save[2*g +: 2]        = gate_res[g].save;
      res_save_closed[2*g +: 2] = gate_res[g].save_closed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pwm_brake   <= 16'd0;
      cfg.pwm_run     <= 16'hFFFF;
      cfg.angle_brake <= 6'd10;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_PWM_BRAKE:   cfg.pwm_brake   <= cfg_data;
        REG_PWM_RUN:     cfg.pwm_run     <= cfg_data;
        REG_ANGLE_BRAKE: cfg.angle_brake <= cfg_data[5:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int g = 0; g < NUM_GATES; g++) begin
        gate_st[g] <= '0;
      end
      move_lamp <= 1'b0;
      rain_lamp <= 1'b0;
    end else if (accept) begin
      for (int g = 0; g < NUM_GATES; g++) begin
        gate_st[g] <= gate_res[g].st;
      end
      move_lamp <= move_lamp_next;
      rain_lamp <= rain_lamp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {res_save_closed, res_save,
                  {rain_lamp_next, move_lamp_next, res_end},
                  res_modes, res_speed[1], res_speed[0], res_dirs};
    end
  end

endmodule
